// File: rtl/bpr_pkg.sv
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared types and constants for the byte pattern replace block.
// ----------------------------------------------------------------------------
package bpr_pkg;

	localparam int BYTE_W     = 8;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int LEN_W      = 4;
	// selects one of the eight bytes of a 64-bit pattern or replacement
	localparam int BYTE_SEL_W = 3;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN = 2'd0,
		REG_REPLACE = 2'd1,
		REG_LENGTH  = 2'd2
	} cfg_reg_t;

endpackage

// File: rtl/byte_pattern_replace_top.sv
// ----------------------------------------------------------------------------
// byte_pattern_replace_top
// Byte stream search and replace with a configurable pattern of 1..8 bytes.
// ----------------------------------------------------------------------------
// Bytes enter on the in_* channel and leave, in order, on the out_* channel,
// with every occurrence of the configured pattern overwritten by the
// replacement of the same length. Overlapping matches see bytes already
// replaced, as an in-place left-to-right scan would. The block holds the
// newest L-1 bytes (L = pattern_length) until no later match can reach them,
// so output lags input by L-1 bytes; the request flagged in_last flushes
// every held byte, the final one carrying out_last. Streams shorter than L
// pass through untouched. Throughput is one byte per cycle in both
// directions while out_ready stays high: the head of the window register
// doubles as the output register, so a new byte is taken while the
// previous result still waits. After an in_last request the flush drains
// the held bytes at one per cycle while out_ready is high, and input is
// held off until the final byte has been accepted downstream, so the next
// stream's first request waits for the whole flush. A pattern_length of 0
// acts as 1 and values above MAX_PATTERN act as MAX_PATTERN. The user must
// write the registers through cfg_we / cfg_index / cfg_data only while the
// block is idle: 0 pattern, 1 replacement (byte 0 in bits 7:0, first byte
// first), 2 length. The block itself does not enforce the idle rule.
// ----------------------------------------------------------------------------
module byte_pattern_replace_top #(
	parameter int MAX_PATTERN = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [bpr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bpr_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input stream
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bpr_pkg::BYTE_W-1:0]      data_byte,
	input  logic                            in_last,
	// output stream
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bpr_pkg::BYTE_W-1:0]      out_byte,
	output logic                            out_last
);
	import bpr_pkg::*;

	// one slot beyond the pattern so a byte owed downstream can wait at the
	// head while the next byte enters
	localparam int Depth = MAX_PATTERN + 1;
	localparam int CntW  = $clog2(Depth + 1);
	localparam int IdxW  = $clog2(Depth);

	// configuration registers
	logic [CFG_DATA_W-1:0] pattern_q;
	logic [CFG_DATA_W-1:0] replace_q;
	logic [LEN_W-1:0]      length_q;

	// window: slots [0, owe_q) are owed downstream, [owe_q, cnt_q) are held
	byte_t             win_q [Depth];
	logic [CntW-1:0]   cnt_q;
	logic [CntW-1:0]   owe_q;
	logic              flush_q;

	logic              pop;
	logic              take;
	logic [CntW-1:0]   act_len;
	byte_t             win_pop [Depth];
	byte_t             win_ins [Depth];
	byte_t             win_new [Depth];
	logic [CntW-1:0]   cnt1;
	logic [CntW-1:0]   owe1;
	logic [CntW-1:0]   held1;
	logic [CntW-1:0]   cnt2;
	logic [CntW-1:0]   held2;
	logic [CntW-1:0]   held_keep;
	logic [CntW-1:0]   base;
	logic              cmp_en;
	logic [CntW-1:0]   owe_d;
	logic              flush_d;

	// ---- configuration writes ----------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			replace_q <= '0;
			length_q  <= LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN: pattern_q <= cfg_data;
				REG_REPLACE: replace_q <= cfg_data;
				REG_LENGTH:  length_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// active length, clamped to 1..MAX_PATTERN
	always_comb begin
		if (length_q == '0) begin
			act_len = CntW'(1);
		end else if (length_q > LEN_W'(MAX_PATTERN)) begin
			act_len = CntW'(MAX_PATTERN);
		end else begin
			act_len = CntW'(length_q);
		end
	end

	// ---- handshakes --------------------------------------------------------
	assign out_valid = (owe_q != '0);
	assign out_byte  = win_q[0];
	assign out_last  = flush_q && (owe_q == CntW'(1));

	// at most one owed byte may wait while a new byte enters; a flush must
	// drain first
	assign in_ready  = (owe_q == '0) || ((owe_q == CntW'(1)) && !flush_q);

	assign pop  = out_valid && out_ready;
	assign take = in_valid && in_ready;

	// ---- step logic --------------------------------------------------------
	// head leaves first
	always_comb begin
		for (int j = 0; j < Depth - 1; j++) begin
			win_pop[j] = pop ? win_q[j+1] : win_q[j];
		end
		win_pop[Depth-1] = win_q[Depth-1];
	end

	assign cnt1  = cnt_q - CntW'(pop);
	assign owe1  = owe_q - CntW'(pop);
	assign held1 = cnt1 - owe1;

	// new byte lands just after the last occupied slot
	always_comb begin
		for (int j = 0; j < Depth; j++) begin
			win_ins[j] = win_pop[j];
		end
		if (take) begin
			win_ins[cnt1[IdxW-1:0]] = data_byte;
		end
	end

	assign cnt2   = cnt1 + CntW'(take);
	assign held2  = held1 + CntW'(take);
	assign cmp_en = take && (held2 >= act_len);
	assign base   = cnt2 - act_len;

	bpr_match #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_match (
		.win_in  (win_ins),
		.base    (base),
		.top     (cnt2),
		.cmp_en  (cmp_en),
		.pattern (pattern_q),
		.replace (replace_q),
		.win_out (win_new)
	);

	// keep the newest L-1 bytes; anything older is owed now
	always_comb begin
		if (held2 > act_len - CntW'(1)) begin
			held_keep = act_len - CntW'(1);
		end else begin
			held_keep = held2;
		end
		if (take && in_last) begin
			owe_d   = cnt2;
			flush_d = 1'b1;
		end else if (take) begin
			owe_d   = cnt2 - held_keep;
			flush_d = 1'b0;
		end else begin
			owe_d   = owe1;
			flush_d = flush_q && (owe1 != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			owe_q   <= '0;
			flush_q <= 1'b0;
		end else begin
			cnt_q   <= cnt2;
			owe_q   <= owe_d;
			flush_q <= flush_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < Depth; j++) begin
			win_q[j] <= win_new[j];
		end
	end

	// ---- assertions --------------------------------------------------------
	a_owe_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		owe_q <= cnt_q)
		else $error("owed count exceeds window occupancy");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q - owe_q) < CntW'(MAX_PATTERN))
		else $error("more than MAX_PATTERN-1 bytes held back");

	a_flush_all_owed: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> (owe_q == cnt_q))
		else $error("flush with bytes still held back");

	a_last_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(take && in_last) |=> (flush_q && out_valid))
		else $error("last request did not start a flush");

endmodule

// File: rtl/bpr_match.sv
// ----------------------------------------------------------------------------
// bpr_match
// Compares a run of window slots [base, top) with the pattern and, when
// cmp_en is set and every byte matches, overwrites the run with the replacement.
// ----------------------------------------------------------------------------
module bpr_match #(
	parameter int MAX_PATTERN = 8
) (
	input  bpr_pkg::byte_t                             win_in  [MAX_PATTERN+1],
	input  logic [$clog2(MAX_PATTERN+2)-1:0]           base,
	input  logic [$clog2(MAX_PATTERN+2)-1:0]           top,
	input  logic                                       cmp_en,
	input  logic [bpr_pkg::CFG_DATA_W-1:0]             pattern,
	input  logic [bpr_pkg::CFG_DATA_W-1:0]             replace,
	output bpr_pkg::byte_t                             win_out [MAX_PATTERN+1]
);
	import bpr_pkg::*;

	localparam int Depth = MAX_PATTERN + 1;
	localparam int CntW  = $clog2(Depth + 1);

	logic [BYTE_SEL_W-1:0] sel    [Depth];
	logic                  in_run [Depth];
	logic                  hit;

	// slot j maps to pattern byte j - base while it lies inside the run
	always_comb begin
		for (int j = 0; j < Depth; j++) begin
			in_run[j] = (CntW'(j) >= base) && (CntW'(j) < top);
			sel[j]    = BYTE_SEL_W'(CntW'(j) - base);
		end
	end

	always_comb begin
		hit = cmp_en;
		for (int j = 0; j < Depth; j++) begin
			if (in_run[j] && (win_in[j] != pattern[sel[j]*BYTE_W +: BYTE_W])) begin
				hit = 1'b0;
			end
		end
	end

	always_comb begin
		for (int j = 0; j < Depth; j++) begin
			if (hit && in_run[j]) begin
				win_out[j] = replace[sel[j]*BYTE_W +: BYTE_W];
			end else begin
				win_out[j] = win_in[j];
			end
		end
	end

endmodule
